[rtl/core/urft_pkg.sv]
`default_nettype none

package urft_pkg;

  localparam int ANCHORS = 3;

  // Input command codes carried in the slave tuser field.
  localparam logic [1:0] CMD_MAIN  = 2'd0;
  localparam logic [1:0] CMD_B     = 2'd1;
  localparam logic [1:0] CMD_C     = 2'd2;
  localparam logic [1:0] CMD_ANGLE = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_MIN_RANGE = 3'd0;
  localparam logic [2:0] REG_SELF_X    = 3'd1;
  localparam logic [2:0] REG_SELF_Y    = 3'd2;
  localparam logic [2:0] REG_B_X       = 3'd3;
  localparam logic [2:0] REG_B_Y       = 3'd4;
  localparam logic [2:0] REG_C_X       = 3'd5;
  localparam logic [2:0] REG_C_Y       = 3'd6;

  // Multiply-accumulate program: steps that close a result.
  localparam logic [4:0] STEP_C    = 5'd5;
  localparam logic [4:0] STEP_F    = 5'd11;
  localparam logic [4:0] STEP_DET  = 5'd13;
  localparam logic [4:0] STEP_NX   = 5'd15;
  localparam logic [4:0] STEP_LAST = 5'd17;

  // Divider width (numerator magnitude bits, one bit per cycle).
  localparam int DIV_BITS = 54;

  // Angle constants, radians in Q12.
  localparam logic signed [16:0] PI_Q12      = 17'sd12868;
  localparam logic signed [16:0] TWO_PI_Q12  = 17'sd25736;
  localparam logic signed [16:0] HALF_PI_Q12 = 17'sd6434;

  localparam logic signed [17:0] CORDIC_GAIN = 18'sd39797;
  localparam logic [3:0]         CORDIC_LAST = 4'd15;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_F_READ,
    ST_F_UPDATE,
    ST_DIV_AVG,
    ST_MAC_MUL,
    ST_MAC_ACC,
    ST_DIV_QX,
    ST_DIV_QY,
    ST_ROT_PREP,
    ST_ROT_ITER,
    ST_GAIN_X_MUL,
    ST_GAIN_X,
    ST_GAIN_Y_MUL,
    ST_GAIN_Y,
    ST_OUT_WAIT
  } state_t;

  typedef enum logic [1:0] {
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  // Arctangent of 2^-i in Q16 radians.
  function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
    logic signed [19:0] v;
    case (i)
      4'd0:    v = 20'sd51472;
      4'd1:    v = 20'sd30386;
      4'd2:    v = 20'sd16055;
      4'd3:    v = 20'sd8150;
      4'd4:    v = 20'sd4091;
      4'd5:    v = 20'sd2047;
      4'd6:    v = 20'sd1024;
      4'd7:    v = 20'sd512;
      4'd8:    v = 20'sd256;
      4'd9:    v = 20'sd128;
      4'd10:   v = 20'sd64;
      4'd11:   v = 20'sd32;
      4'd12:   v = 20'sd16;
      4'd13:   v = 20'sd8;
      4'd14:   v = 20'sd4;
      default: v = 20'sd2;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/uwb_range_filter_trilaterate_unit.sv]
`default_nettype none

// Three-anchor 2D UWB position unit. Range transactions (tuser 0 main, 1 anchor B,
// 2 anchor C) feed a per-anchor boxcar average of WINDOW samples; a range not above
// min_range_mm leaves the average untouched. An angle transaction (tuser 3) stores
// the rotation angle. Each anchor-C transaction, whether its range was kept or not,
// produces one result: the tag position solved from the three averaged ranges and
// the configured anchor positions, rotated by minus the stored angle and saturated
// to 16 bits, together with the three averaged ranges. A zero anchor determinant
// sets the singular flag and reports position zero. All solver arithmetic goes
// through one shared 36x18 multiplier, one bit-per-cycle divider and one CORDIC
// stage under a sequencer, and s_tready is low while a transaction is in work. The
// average is taken by multiplying the window sum with a reciprocal constant. An angle
// transaction, or an ignored main/B range, completes on acceptance; a kept main/B
// range passes through accept, memory read, update and reciprocal multiply; an
// anchor-C transaction (after those filter steps when its range is kept) runs the
// multiply-accumulate program, the two divides, 16 CORDIC iterations, the gain
// scaling and the output hand-off, skipping divides, CORDIC and gain when singular.
// A finished result waits for the output register to be free and then sits there
// until taken, so the next transaction may be accepted meanwhile. Configuration is
// to be written only while the unit is idle; the unit does not enforce this. The
// store clears at reset through per-entry valid bits, so no clearing pass is needed.
module uwb_range_filter_trilaterate_unit #(
  parameter int WINDOW = 15
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] range_mm, [31:16] angle
  input  wire logic [1:0]  s_tuser,   // [1:0] command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // [15:0] pos_x, [31:16] pos_y, [47:32] filt_main,
                                      // [63:48] filt_b, [79:64] filt_c
  output logic [0:0]       m_tuser,   // [0] singular
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int DEPTH = urft_pkg::ANCHORS * WINDOW;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = 16 + $clog2(WINDOW);
  localparam int DB    = urft_pkg::DIV_BITS;

  // Reciprocal of WINDOW, exact floor for every sum below 2^SUM_W.
  localparam int RSH = SUM_W + $clog2(WINDOW);
  localparam int RW  = SUM_W + 2;
  localparam int PW  = SUM_W + RW;
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << RSH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  // Configuration registers.
  logic        [15:0] min_range_mm;
  logic signed [15:0] anchor_self_x, anchor_self_y;
  logic signed [15:0] anchor_b_x, anchor_b_y, anchor_c_x, anchor_c_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_range_mm  <= 16'd200;
      anchor_self_x <= 16'sd0;
      anchor_self_y <= 16'sd0;
      anchor_b_x    <= 16'sd425;
      anchor_b_y    <= -16'sd550;
      anchor_c_x    <= -16'sd425;
      anchor_c_y    <= -16'sd550;
    end else if (cfg_we) begin
      case (cfg_index)
        urft_pkg::REG_MIN_RANGE: min_range_mm  <= cfg_data;
        urft_pkg::REG_SELF_X:    anchor_self_x <= cfg_data;
        urft_pkg::REG_SELF_Y:    anchor_self_y <= cfg_data;
        urft_pkg::REG_B_X:       anchor_b_x    <= cfg_data;
        urft_pkg::REG_B_Y:       anchor_b_y    <= cfg_data;
        urft_pkg::REG_C_X:       anchor_c_x    <= cfg_data;
        urft_pkg::REG_C_Y:       anchor_c_y    <= cfg_data;
        default: ;
      endcase
    end
  end

  urft_pkg::state_t state, state_next;

  // Latched transaction.
  logic [1:0]  cmd;
  logic [15:0] range_q;

  // Filter state.
  logic [15:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [15:0]      rd_data;
  logic             rd_vld;
  logic [SUM_W-1:0] sums  [urft_pkg::ANCHORS];
  logic [SW-1:0]    slots [urft_pkg::ANCHORS];
  logic [15:0]      avg   [urft_pkg::ANCHORS];
  logic [15:0]      stored_angle;

  logic [AW-1:0]    addr;
  logic [15:0]      old_sample;
  logic [SUM_W-1:0] sum_new;
  logic [PW-1:0]    avg_prod;

  assign addr       = AW'(cmd) * AW'(WINDOW) + AW'(slots[cmd]);
  assign old_sample = rd_vld ? rd_data : 16'd0;
  assign sum_new    = sums[cmd] - SUM_W'(old_sample) + SUM_W'(range_q);
  assign avg_prod   = PW'(sums[cmd]) * PW'(RECIP);

  // Solver coefficients: A = 2(bx-sx), B = 2(by-sy), D = 2(cx-bx), E = 2(cy-by).
  logic signed [17:0] coef_a, coef_b, coef_d, coef_e;
  assign coef_a = 18'(17'(anchor_b_x) - 17'(anchor_self_x)) <<< 1;
  assign coef_b = 18'(17'(anchor_b_y) - 17'(anchor_self_y)) <<< 1;
  assign coef_d = 18'(17'(anchor_c_x) - 17'(anchor_b_x)) <<< 1;
  assign coef_e = 18'(17'(anchor_c_y) - 17'(anchor_b_y)) <<< 1;

  logic signed [17:0] rs, rb, rc;
  assign rs = $signed({2'b00, avg[0]});
  assign rb = $signed({2'b00, avg[1]});
  assign rc = $signed({2'b00, avg[2]});

  // Shared multiplier and accumulator.
  logic signed [35:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [53:0] prod, acc, acc_next;
  urft_pkg::acc_op_t  acc_op;
  logic [4:0]         step;

  logic signed [34:0] c_val, f_val;
  logic signed [36:0] det;
  logic signed [53:0] numx, numy;

  // CORDIC registers.
  logic signed [35:0] cx_r, cy_r;
  logic signed [19:0] cz;
  logic [3:0]         ci;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    acc_op = urft_pkg::ACC_ADD;
    case (state)
      urft_pkg::ST_MAC_MUL, urft_pkg::ST_MAC_ACC: begin
        case (step)
          5'd0:  begin mul_a = 36'(rs);            mul_b = rs;
                       acc_op = urft_pkg::ACC_LOAD; end
          5'd1:  begin mul_a = 36'(rb);            mul_b = rb;
                       acc_op = urft_pkg::ACC_SUB;  end
          5'd2:  begin mul_a = 36'(anchor_self_x); mul_b = 18'(anchor_self_x);
                       acc_op = urft_pkg::ACC_SUB;  end
          5'd3:  begin mul_a = 36'(anchor_b_x);    mul_b = 18'(anchor_b_x);
                       acc_op = urft_pkg::ACC_ADD;  end
          5'd4:  begin mul_a = 36'(anchor_self_y); mul_b = 18'(anchor_self_y);
                       acc_op = urft_pkg::ACC_SUB;  end
          5'd5:  begin mul_a = 36'(anchor_b_y);    mul_b = 18'(anchor_b_y);
                       acc_op = urft_pkg::ACC_ADD;  end
          5'd6:  begin mul_a = 36'(rb);            mul_b = rb;
                       acc_op = urft_pkg::ACC_LOAD; end
          5'd7:  begin mul_a = 36'(rc);            mul_b = rc;
                       acc_op = urft_pkg::ACC_SUB;  end
          5'd8:  begin mul_a = 36'(anchor_b_x);    mul_b = 18'(anchor_b_x);
                       acc_op = urft_pkg::ACC_SUB;  end
          5'd9:  begin mul_a = 36'(anchor_c_x);    mul_b = 18'(anchor_c_x);
                       acc_op = urft_pkg::ACC_ADD;  end
          5'd10: begin mul_a = 36'(anchor_b_y);    mul_b = 18'(anchor_b_y);
                       acc_op = urft_pkg::ACC_SUB;  end
          5'd11: begin mul_a = 36'(anchor_c_y);    mul_b = 18'(anchor_c_y);
                       acc_op = urft_pkg::ACC_ADD;  end
          5'd12: begin mul_a = 36'(coef_e);        mul_b = coef_a;
                       acc_op = urft_pkg::ACC_LOAD; end
          5'd13: begin mul_a = 36'(coef_b);        mul_b = coef_d;
                       acc_op = urft_pkg::ACC_SUB;  end
          5'd14: begin mul_a = 36'(c_val);         mul_b = coef_e;
                       acc_op = urft_pkg::ACC_LOAD; end
          5'd15: begin mul_a = 36'(f_val);         mul_b = coef_b;
                       acc_op = urft_pkg::ACC_SUB;  end
          5'd16: begin mul_a = 36'(c_val);         mul_b = coef_d;
                       acc_op = urft_pkg::ACC_LOAD; end
          5'd17: begin mul_a = 36'(f_val);         mul_b = coef_a;
                       acc_op = urft_pkg::ACC_SUB;  end
          default: ;
        endcase
      end
      urft_pkg::ST_GAIN_X_MUL: begin
        mul_a = cx_r;
        mul_b = urft_pkg::CORDIC_GAIN;
      end
      urft_pkg::ST_GAIN_Y_MUL: begin
        mul_a = cy_r;
        mul_b = urft_pkg::CORDIC_GAIN;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (acc_op)
      urft_pkg::ACC_LOAD: acc_next = prod;
      urft_pkg::ACC_SUB:  acc_next = acc - prod;
      default:            acc_next = acc + prod;
    endcase
  end

  // Restoring divider, one quotient bit per cycle, on magnitudes.
  logic [DB-1:0] div_num, div_q, div_q_next;
  logic [36:0]   div_den, div_rem;
  logic          div_neg;
  logic [5:0]    div_cnt;
  logic [37:0]   rem_sh;
  logic [38:0]   rem_diff;
  logic          div_ge, div_done;

  assign rem_sh     = {div_rem, div_num[DB-1]};
  assign rem_diff   = {1'b0, rem_sh} - {2'b00, div_den};
  assign div_ge     = !rem_diff[38];
  assign div_q_next = {div_q[DB-2:0], div_ge};
  assign div_done   = (div_cnt == 6'(DB - 1));

  // Truncated signed quotient, clamped to 24 bits.
  logic signed [23:0] q_sat;
  always_comb begin
    if (div_neg) begin
      if (div_q_next > DB'(24'h800000)) q_sat = 24'sh800000;
      else                              q_sat = -$signed(div_q_next[23:0]);
    end else begin
      if (div_q_next > DB'(24'h7FFFFF)) q_sat = 24'sh7FFFFF;
      else                              q_sat = $signed(div_q_next[23:0]);
    end
  end

  logic [DB-1:0] numx_mag, numy_mag;
  logic [36:0]   det_mag;
  assign numx_mag = numx[DB-1] ? DB'(-numx) : DB'(numx);
  assign numy_mag = numy[DB-1] ? DB'(-numy) : DB'(numy);
  assign det_mag  = det[36] ? 37'(-det) : 37'(det);

  logic signed [23:0] qx, qy;

  // Rotation set-up: wrap the stored angle to [-pi, pi], negate, fold by quarter turns.
  logic signed [16:0] phi0, phi_w, nphi, phi_f;
  logic signed [24:0] xr, yr;
  always_comb begin
    phi0 = 17'($signed(stored_angle));
    if (phi0 > urft_pkg::PI_Q12)       phi_w = phi0 - urft_pkg::TWO_PI_Q12;
    else if (phi0 < -urft_pkg::PI_Q12) phi_w = phi0 + urft_pkg::TWO_PI_Q12;
    else                               phi_w = phi0;
    nphi = -phi_w;
    if (nphi > urft_pkg::HALF_PI_Q12) begin
      xr    = -25'(qy);
      yr    = 25'(qx);
      phi_f = nphi - urft_pkg::HALF_PI_Q12;
    end else if (nphi < -urft_pkg::HALF_PI_Q12) begin
      xr    = 25'(qy);
      yr    = -25'(qx);
      phi_f = nphi + urft_pkg::HALF_PI_Q12;
    end else begin
      xr    = 25'(qx);
      yr    = 25'(qy);
      phi_f = nphi;
    end
  end

  logic signed [35:0] dx, dy;
  logic signed [19:0] atan_i;
  assign dx     = cy_r >>> ci;
  assign dy     = cx_r >>> ci;
  assign atan_i = urft_pkg::atan_q16(ci);

  // Gain scaling with round half up, then saturation to 16 bits.
  logic signed [53:0] gain_sum;
  logic signed [29:0] gain_res;
  logic signed [15:0] gain_sat;
  assign gain_sum = prod + 54'sd8388608;
  assign gain_res = gain_sum[53:24];
  always_comb begin
    if (gain_res > 30'sd32767)       gain_sat = 16'sh7FFF;
    else if (gain_res < -30'sd32768) gain_sat = 16'sh8000;
    else                             gain_sat = gain_res[15:0];
  end

  logic signed [15:0] pos_x, pos_y;
  logic               singular;

  logic s_fire, keep_range, out_free;
  assign s_fire     = s_tvalid && s_tready;
  assign keep_range = (s_tdata[15:0] > min_range_mm);
  assign out_free   = !m_tvalid || m_tready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      urft_pkg::ST_IDLE: begin
        if (s_fire && (s_tuser != urft_pkg::CMD_ANGLE)) begin
          if (keep_range)                        state_next = urft_pkg::ST_F_READ;
          else if (s_tuser == urft_pkg::CMD_C)   state_next = urft_pkg::ST_MAC_MUL;
        end
      end
      urft_pkg::ST_F_READ:   state_next = urft_pkg::ST_F_UPDATE;
      urft_pkg::ST_F_UPDATE: state_next = urft_pkg::ST_DIV_AVG;
      urft_pkg::ST_DIV_AVG: begin
        if (cmd == urft_pkg::CMD_C) state_next = urft_pkg::ST_MAC_MUL;
        else                        state_next = urft_pkg::ST_IDLE;
      end
      urft_pkg::ST_MAC_MUL: state_next = urft_pkg::ST_MAC_ACC;
      urft_pkg::ST_MAC_ACC: begin
        if (step != urft_pkg::STEP_LAST)   state_next = urft_pkg::ST_MAC_MUL;
        else if (det == '0)                state_next = urft_pkg::ST_OUT_WAIT;
        else                               state_next = urft_pkg::ST_DIV_QX;
      end
      urft_pkg::ST_DIV_QX:     if (div_done) state_next = urft_pkg::ST_DIV_QY;
      urft_pkg::ST_DIV_QY:     if (div_done) state_next = urft_pkg::ST_ROT_PREP;
      urft_pkg::ST_ROT_PREP:   state_next = urft_pkg::ST_ROT_ITER;
      urft_pkg::ST_ROT_ITER: begin
        if (ci == urft_pkg::CORDIC_LAST) state_next = urft_pkg::ST_GAIN_X_MUL;
      end
      urft_pkg::ST_GAIN_X_MUL: state_next = urft_pkg::ST_GAIN_X;
      urft_pkg::ST_GAIN_X:     state_next = urft_pkg::ST_GAIN_Y_MUL;
      urft_pkg::ST_GAIN_Y_MUL: state_next = urft_pkg::ST_GAIN_Y;
      urft_pkg::ST_GAIN_Y:     state_next = urft_pkg::ST_OUT_WAIT;
      urft_pkg::ST_OUT_WAIT:   if (out_free) state_next = urft_pkg::ST_IDLE;
      default:                 state_next = urft_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_tready = (state == urft_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= urft_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Sample memory with registered read.
  always_ff @(posedge clk) begin
    if (state == urft_pkg::ST_F_READ) rd_data <= mem[addr];
    if (state == urft_pkg::ST_F_UPDATE) mem[addr] <= range_q;
  end

  // Filter control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      rd_vld       <= 1'b0;
      stored_angle <= '0;
      for (int k = 0; k < urft_pkg::ANCHORS; k++) begin
        sums[k]  <= '0;
        slots[k] <= '0;
        avg[k]   <= '0;
      end
    end else begin
      if (s_fire && (s_tuser == urft_pkg::CMD_ANGLE)) stored_angle <= s_tdata[31:16];
      if (state == urft_pkg::ST_F_READ) rd_vld <= vld[addr];
      if (state == urft_pkg::ST_F_UPDATE) begin
        vld[addr] <= 1'b1;
        sums[cmd] <= sum_new;
        if (slots[cmd] == SW'(WINDOW - 1)) slots[cmd] <= '0;
        else                               slots[cmd] <= slots[cmd] + SW'(1);
      end
      if (state == urft_pkg::ST_DIV_AVG) avg[cmd] <= avg_prod[RSH +: 16];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (s_fire) begin
      cmd     <= s_tuser;
      range_q <= s_tdata[15:0];
      step    <= '0;
    end

    if (state == urft_pkg::ST_MAC_ACC) begin
      acc  <= acc_next;
      step <= step + 5'd1;
      case (step)
        urft_pkg::STEP_C:    c_val <= acc_next[34:0];
        urft_pkg::STEP_F:    f_val <= acc_next[34:0];
        urft_pkg::STEP_DET:  det   <= acc_next[36:0];
        urft_pkg::STEP_NX:   numx  <= acc_next;
        urft_pkg::STEP_LAST: numy  <= acc_next;
        default: ;
      endcase
    end

    // Divider loading and iteration.
    case (state)
      urft_pkg::ST_MAC_ACC: begin
        div_num <= numx_mag;
        div_den <= det_mag;
        div_neg <= numx[DB-1] ^ det[36];
        div_rem <= '0;
        div_cnt <= '0;
      end
      urft_pkg::ST_DIV_QX, urft_pkg::ST_DIV_QY: begin
        div_num <= div_num << 1;
        div_q   <= div_q_next;
        div_rem <= div_ge ? rem_diff[36:0] : rem_sh[36:0];
        div_cnt <= div_cnt + 6'd1;
        if ((state == urft_pkg::ST_DIV_QX) && div_done) begin
          qx      <= q_sat;
          div_num <= numy_mag;
          div_den <= det_mag;
          div_neg <= numy[DB-1] ^ !det[36];
          div_rem <= '0;
          div_cnt <= '0;
        end
        if ((state == urft_pkg::ST_DIV_QY) && div_done) qy <= q_sat;
      end
      urft_pkg::ST_ROT_PREP: begin
        cx_r <= 36'(xr) <<< 8;
        cy_r <= 36'(yr) <<< 8;
        cz   <= 20'(phi_f) <<< 4;
        ci   <= '0;
      end
      urft_pkg::ST_ROT_ITER: begin
        if (!cz[19]) begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          cz   <= cz - atan_i;
        end else begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          cz   <= cz + atan_i;
        end
        ci <= ci + 4'd1;
      end
      urft_pkg::ST_GAIN_X: pos_x <= gain_sat;
      urft_pkg::ST_GAIN_Y: pos_y <= gain_sat;
      default: ;
    endcase

    // A singular geometry skips the solve and reports the origin.
    if ((state == urft_pkg::ST_MAC_ACC) && (step == urft_pkg::STEP_LAST)) begin
      singular <= (det == '0);
      if (det == '0) begin
        pos_x <= '0;
        pos_y <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == urft_pkg::ST_OUT_WAIT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == urft_pkg::ST_OUT_WAIT) && out_free) begin
      m_tdata <= {avg[2], avg[1], avg[0], pos_y, pos_x};
      m_tuser <= singular;
    end
  end

endmodule

`default_nettype wire
